>>> hdl/i2r_pkg.sv
package i2r_pkg;

   localparam int VALUE_W = 12;
   localparam int CHAR_W  = 7;
   localparam int IDX_W   = 4;
   localparam int TOK_W   = 10;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;
   localparam logic [IDX_W-1:0]   IDX_LAST  = 4'd12;

   localparam logic [CHAR_W-1:0] CH_NONE = 7'd0;
   localparam logic [CHAR_W-1:0] CH_I    = 7'h49;
   localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
   localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
   localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
   localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
   localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
   localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;

   // result of one pass through the shared compare/subtract unit
   typedef struct packed {
      logic                ge;
      logic [VALUE_W-1:0]  diff;
      logic [CHAR_W-1:0]   char1;
      logic [CHAR_W-1:0]   char2;
      logic                two;
   } step_type;

   // token table, largest first: M CM D CD C XC L XL X IX V IV I
   function automatic logic [TOK_W-1:0] tok_val(input logic [IDX_W-1:0] idx);
      case (idx)
         4'd0:    tok_val = 10'd1000;
         4'd1:    tok_val = 10'd900;
         4'd2:    tok_val = 10'd500;
         4'd3:    tok_val = 10'd400;
         4'd4:    tok_val = 10'd100;
         4'd5:    tok_val = 10'd90;
         4'd6:    tok_val = 10'd50;
         4'd7:    tok_val = 10'd40;
         4'd8:    tok_val = 10'd10;
         4'd9:    tok_val = 10'd9;
         4'd10:   tok_val = 10'd5;
         4'd11:   tok_val = 10'd4;
         default: tok_val = 10'd1;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] tok_char1(input logic [IDX_W-1:0] idx);
      case (idx)
         4'd0:    tok_char1 = CH_M;
         4'd1:    tok_char1 = CH_C;
         4'd2:    tok_char1 = CH_D;
         4'd3:    tok_char1 = CH_C;
         4'd4:    tok_char1 = CH_C;
         4'd5:    tok_char1 = CH_X;
         4'd6:    tok_char1 = CH_L;
         4'd7:    tok_char1 = CH_X;
         4'd8:    tok_char1 = CH_X;
         4'd9:    tok_char1 = CH_I;
         4'd10:   tok_char1 = CH_V;
         4'd11:   tok_char1 = CH_I;
         default: tok_char1 = CH_I;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] tok_char2(input logic [IDX_W-1:0] idx);
      case (idx)
         4'd1:    tok_char2 = CH_M;
         4'd3:    tok_char2 = CH_D;
         4'd5:    tok_char2 = CH_C;
         4'd7:    tok_char2 = CH_L;
         4'd9:    tok_char2 = CH_X;
         4'd11:   tok_char2 = CH_V;
         default: tok_char2 = CH_NONE;
      endcase
   endfunction

endpackage

>>> hdl/i2r_step.sv
module i2r_step
   import i2r_pkg::*;
(
   input  logic [VALUE_W-1:0] rem,
   input  logic [IDX_W-1:0]   idx,
   output step_type           step
);

   logic [VALUE_W-1:0] val;

   // one compare and one subtract against the selected token
   assign val        = {{(VALUE_W-TOK_W){1'b0}}, tok_val(idx)};
   assign step.ge    = (rem >= val);
   assign step.diff  = rem - val;
   assign step.char1 = tok_char1(idx);
   assign step.char2 = tok_char2(idx);
   assign step.two   = (tok_char2(idx) != CH_NONE);

endmodule

>>> hdl/integer_to_roman.sv
// Integer to Roman numeral converter. Each accepted word on req_value (1 to 3999) is
// turned into a run of ASCII letters on the rsp_ channel, most significant first, with
// rsp_last on the final letter; values of 0 or above 3999 give a single word with
// rsp_char_code 0, rsp_last 1 and rsp_bad_value 1. The block holds req_stall high from
// the cycle after acceptance until the last letter is loaded into the output register.
// A sequencer walks a 13-row token table (M CM D CD C XC L XL X IX V IV I) through one
// shared compare/subtract unit: in every cycle that the output register is free, it
// either sends one letter or steps to the next row; while a full output register is
// stalled, the sequencer waits.
module integer_to_roman
   import i2r_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_char_code,
   output logic               rsp_last,
   output logic               rsp_bad_value
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic               state_ff, state_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               half_ff, half_in;
   logic               bad_ff, bad_in;

   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic               out_bad_ff, out_bad_in;

   logic               req_take;
   logic               slot_free;
   step_type           step;

   i2r_step u_step (
      .rem  (rem_ff),
      .idx  (idx_ff),
      .step (step)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !out_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      half_in      = half_ff;
      bad_in       = bad_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
               rem_in   = req_value;
               idx_in   = '0;
               half_in  = 1'b0;
               bad_in   = (req_value == '0) || (req_value > VALUE_MAX);
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               if (bad_ff) begin
                  // single error word
                  out_valid_in = 1'b1;
                  out_char_in  = CH_NONE;
                  out_last_in  = 1'b1;
                  out_bad_in   = 1'b1;
                  state_in     = ST_IDLE;
               end else if (half_ff) begin
                  // second letter of a subtractive pair
                  out_valid_in = 1'b1;
                  out_char_in  = step.char2;
                  out_last_in  = (step.diff == '0);
                  out_bad_in   = 1'b0;
                  rem_in       = step.diff;
                  half_in      = 1'b0;
                  if (step.diff == '0) state_in = ST_IDLE;
               end else if (step.ge) begin
                  out_valid_in = 1'b1;
                  out_char_in  = step.char1;
                  out_bad_in   = 1'b0;
                  if (step.two) begin
                     out_last_in = 1'b0;
                     half_in     = 1'b1;
                  end else begin
                     out_last_in = (step.diff == '0);
                     rem_in      = step.diff;
                     if (step.diff == '0) state_in = ST_IDLE;
                  end
               end else if (idx_ff != IDX_LAST) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         half_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         half_ff      <= half_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
      bad_ff      <= bad_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_char_code = out_char_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_bad_value = out_bad_ff;

endmodule

>>> hdl/i2r_checker.sv
module i2r_checker
   import i2r_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [CHAR_W-1:0]  rsp_char_code,
   input  logic               rsp_last,
   input  logic               rsp_bad_value
);

   // error word is a lone, blank, final word
   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_value |-> rsp_last && (rsp_char_code == CH_NONE))
      else $error("bad value word not blank or not last");

   // good words carry a Roman letter
   a_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_value |->
         (rsp_char_code == CH_I) || (rsp_char_code == CH_V) || (rsp_char_code == CH_X) ||
         (rsp_char_code == CH_L) || (rsp_char_code == CH_C) || (rsp_char_code == CH_D) ||
         (rsp_char_code == CH_M))
      else $error("result word is not a Roman letter");

   // busy right after taking a word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again without conversion");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code) &&
         $stable(rsp_last) && $stable(rsp_bad_value))
      else $error("stalled result word changed");

endmodule

bind integer_to_roman i2r_checker u_i2r_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_char_code (rsp_char_code),
   .rsp_last      (rsp_last),
   .rsp_bad_value (rsp_bad_value)
);
